@@ hdl/rci_pkg.sv @@
// ----------------------------------------------------------------------------
// rci_pkg
// Shared types and fixed constants of the ray / circle intersection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rci_pkg;

  // Width of the unsigned radius field.
  localparam int RADIUS_WIDTH = 20;

  // Per-stage control that travels with each word.
  typedef struct packed {
    logic valid;   // stage holds a word
    logic live;    // word can still produce a hit
  } rci_ctl_t;

endpackage

`default_nettype wire

@@ hdl/rci_sqrt_pipe.sv @@
// ----------------------------------------------------------------------------
// rci_sqrt_pipe
// Integer square root, one root bit per register stage (restoring method),
// with a side vector and control delayed to match.
// ----------------------------------------------------------------------------
`default_nettype none

module rci_sqrt_pipe import rci_pkg::*; #(
  parameter int RB     = 50,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  rci_ctl_t          ctl_in,
  input  logic [2*RB-1:0]   rad_in,
  input  logic [SIDE_W-1:0] side_in,
  output rci_ctl_t          ctl_out,
  output logic [RB-1:0]     root_out,
  output logic [SIDE_W-1:0] side_out
);

  rci_ctl_t            ctl_q   [RB];
  logic [RB:0]         rem_q   [RB];
  logic [RB-1:0]       root_q  [RB];
  logic [2*RB-1:0]     rad_q   [RB];
  logic [SIDE_W-1:0]   side_q  [RB];

  rci_ctl_t            ctl_p   [RB];
  logic [RB:0]         rem_p   [RB];
  logic [RB-1:0]       root_p  [RB];
  logic [2*RB-1:0]     rad_p   [RB];
  logic [SIDE_W-1:0]   side_p  [RB];

  logic [RB+2:0]       rem_sh  [RB];
  logic [RB+2:0]       trial   [RB];
  logic [RB+2:0]       diff    [RB];
  logic                take    [RB];

  // Select each stage's source: the inputs for the first, the previous stage after
  always_comb begin
    ctl_p[0]  = ctl_in;
    rem_p[0]  = '0;
    root_p[0] = '0;
    rad_p[0]  = rad_in;
    side_p[0] = side_in;
    for (int k = 1; k < RB; k++) begin
      ctl_p[k]  = ctl_q[k-1];
      rem_p[k]  = rem_q[k-1];
      root_p[k] = root_q[k-1];
      rad_p[k]  = rad_q[k-1];
      side_p[k] = side_q[k-1];
    end
  end

  // Bring down two radicand bits and try the next root bit
  always_comb begin
    for (int k = 0; k < RB; k++) begin
      rem_sh[k] = {rem_p[k], rad_p[k][2*RB-1 -: 2]};
      trial[k]  = (RB+3)'({root_p[k], 2'b01});
      diff[k]   = rem_sh[k] - trial[k];
      take[k]   = rem_sh[k] >= trial[k];
    end
  end

  // Hold the valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < RB; k++) ctl_q[k] <= '0;
    end else if (en) begin
      for (int k = 0; k < RB; k++) ctl_q[k] <= ctl_p[k];
    end
  end

  // Advance remainder, root and side data
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < RB; k++) begin
        rem_q[k]  <= take[k] ? diff[k][RB:0] : rem_sh[k][RB:0];
        root_q[k] <= {root_p[k][RB-2:0], take[k]};
        rad_q[k]  <= {rad_p[k][2*RB-3:0], 2'b00};
        side_q[k] <= side_p[k];
      end
    end
  end

  assign ctl_out  = ctl_q[RB-1];
  assign root_out = root_q[RB-1];
  assign side_out = side_q[RB-1];

endmodule

`default_nettype wire

@@ hdl/rci_div_pipe.sv @@
// ----------------------------------------------------------------------------
// rci_div_pipe
// Unsigned divider, one quotient bit per register stage, with an overflow
// flag when the quotient does not fit in QB bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rci_div_pipe import rci_pkg::*; #(
  parameter int NUM_W  = 78,
  parameter int DEN_W  = 51,
  parameter int QB     = 26,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  rci_ctl_t          ctl_in,
  input  logic [NUM_W-1:0]  num_in,
  input  logic [DEN_W-1:0]  den_in,
  input  logic [SIDE_W-1:0] side_in,
  output rci_ctl_t          ctl_out,
  output logic [QB-1:0]     quo_out,
  output logic              ovf_out,
  output logic [SIDE_W-1:0] side_out
);

  rci_ctl_t          ctl_q  [QB+1];
  logic [DEN_W-1:0]  rem_q  [QB+1];
  logic [DEN_W-1:0]  den_q  [QB+1];
  logic [QB-1:0]     low_q  [QB+1];
  logic [QB-1:0]     quo_q  [QB+1];
  logic              ovf_q  [QB+1];
  logic [SIDE_W-1:0] side_q [QB+1];

  logic [DEN_W-1:0]  top_c;
  logic [DEN_W:0]    sh     [QB+1];
  logic [DEN_W:0]    diff   [QB+1];
  logic              take   [QB+1];

  assign top_c = DEN_W'(num_in[NUM_W-1:QB]);

  // Shift in one numerator bit and subtract where it fits
  always_comb begin
    sh[0]   = '0;
    diff[0] = '0;
    take[0] = 1'b0;
    for (int k = 1; k <= QB; k++) begin
      sh[k]   = {rem_q[k-1], low_q[k-1][QB-1]};
      diff[k] = sh[k] - {1'b0, den_q[k-1]};
      take[k] = sh[k] >= {1'b0, den_q[k-1]};
    end
  end

  // Hold the valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QB; k++) ctl_q[k] <= '0;
    end else if (en) begin
      ctl_q[0] <= ctl_in;
      for (int k = 1; k <= QB; k++) ctl_q[k] <= ctl_q[k-1];
    end
  end

  // Advance the division stages
  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0]  <= top_c;
      den_q[0]  <= den_in;
      low_q[0]  <= num_in[QB-1:0];
      quo_q[0]  <= '0;
      ovf_q[0]  <= top_c >= den_in;
      side_q[0] <= side_in;
      for (int k = 1; k <= QB; k++) begin
        rem_q[k]  <= take[k] ? diff[k][DEN_W-1:0] : sh[k][DEN_W-1:0];
        den_q[k]  <= den_q[k-1];
        low_q[k]  <= {low_q[k-1][QB-2:0], 1'b0};
        quo_q[k]  <= {quo_q[k-1][QB-2:0], take[k]};
        ovf_q[k]  <= ovf_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign ctl_out  = ctl_q[QB];
  assign quo_out  = quo_q[QB];
  assign ovf_out  = ovf_q[QB];
  assign side_out = side_q[QB];

endmodule

`default_nettype wire

@@ hdl/ray_circle_intersect_top.sv @@
// ----------------------------------------------------------------------------
// ray_circle_intersect_top
// Throughput: one word per cycle while the skid stage is empty; the depth is
// set by the bit-per-stage square root (2*COORD_WIDTH+2 stages, for
// COORD_WIDTH >= 19; below that the square root keeps 2*RADIUS_WIDTH stages)
// and divider (COORD_WIDTH+3 stages).
// Reset: synchronous rst clears all valid bits and the output and skid valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_circle_intersect_top import rci_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // start_x, start_y, dir_end_x, dir_end_y, center_x, center_y, circle_radius
  input  logic [((6*COORD_WIDTH+RADIUS_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // hit_x, hit_y
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
  // hit
  output logic [0:0] m_tuser
);

  localparam int W    = COORD_WIDTH;
  localparam int RW   = RADIUS_WIDTH;
  localparam int ODW  = ((2*W+7)/8)*8;
  localparam int DIFW = W+1;
  localparam int MW   = (2*W+2 > 2*RW) ? 2*W+2 : 2*RW;
  localparam int H    = (MW+1)/2;
  localparam int HW   = MW-H;
  localparam int NW   = MW+1;
  localparam int NH   = NW-H;
  localparam int MPW  = W+NW;
  localparam int NNW  = MPW+2;
  localparam int DENW = MW+1;
  localparam int QB   = W+2;
  localparam int VW   = W+4;
  localparam int GW   = 4*W+2;
  localparam int SW   = GW+2*MW+2;
  localparam int OW   = 2*W+1;
  localparam logic signed [VW-1:0] MAXV = VW'((64'sd1 <<< (W-1)) - 64'sd1);
  localparam logic signed [VW-1:0] MINV = -MAXV - VW'(1);

  logic en;
  logic skid_valid;

  assign en       = !skid_valid;
  assign s_tready = en;

  // Unpack input word
  logic signed [W-1:0] in_sx, in_sy, in_ex, in_ey, in_cx, in_cy;
  logic [RW-1:0]       in_r;
  assign in_sx = s_tdata[0*W +: W];
  assign in_sy = s_tdata[1*W +: W];
  assign in_ex = s_tdata[2*W +: W];
  assign in_ey = s_tdata[3*W +: W];
  assign in_cx = s_tdata[4*W +: W];
  assign in_cy = s_tdata[5*W +: W];
  assign in_r  = s_tdata[6*W +: RW];

  // Stage 1: differences
  rci_ctl_t c1;
  logic signed [W-1:0]    sx1, sy1;
  logic signed [DIFW-1:0] dx1, dy1, fx1, fy1;
  logic [RW-1:0]          r1;

  always_ff @(posedge clk) begin
    if (rst) c1 <= '0;
    else if (en) c1 <= '{valid: s_tvalid, live: 1'b1};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx1 <= in_sx;
      sy1 <= in_sy;
      dx1 <= DIFW'(in_ex) - DIFW'(in_sx);
      dy1 <= DIFW'(in_ey) - DIFW'(in_sy);
      fx1 <= DIFW'(in_sx) - DIFW'(in_cx);
      fy1 <= DIFW'(in_sy) - DIFW'(in_cy);
      r1  <= in_r;
    end
  end

  // Stage 2: dot-product terms and direction magnitudes
  rci_ctl_t c2;
  logic signed [2*DIFW-1:0] pxx2, pyy2, pxf2, pyf2, pff2, pgg2;
  logic [2*RW-1:0]          rr2;
  logic [GW-1:0]            geo2;
  logic signed [DIFW-1:0]   ndx1, ndy1;
  logic [W-1:0]             adx1, ady1;

  assign ndx1 = -dx1;
  assign ndy1 = -dy1;
  assign adx1 = dx1[DIFW-1] ? ndx1[W-1:0] : dx1[W-1:0];
  assign ady1 = dy1[DIFW-1] ? ndy1[W-1:0] : dy1[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) c2 <= '0;
    else if (en) c2 <= c1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxx2 <= dx1 * dx1;
      pyy2 <= dy1 * dy1;
      pxf2 <= dx1 * fx1;
      pyf2 <= dy1 * fy1;
      pff2 <= fx1 * fx1;
      pgg2 <= fy1 * fy1;
      rr2  <= r1 * r1;
      geo2 <= {dy1[DIFW-1], dx1[DIFW-1], ady1, adx1, sy1, sx1};
    end
  end

  // Stage 3: A, b, C and root selection
  rci_ctl_t c3;
  logic signed [MW+1:0] a_s, b_s, c_s, nb_s, nc_s;
  logic                 ble_c, cneg_c, czero_c, minus_c, plus_c;
  logic [MW-1:0]        cmag3;
  logic                 cneg3;
  logic [SW-1:0]        side3;

  always_comb begin
    a_s     = (MW+2)'(pxx2) + (MW+2)'(pyy2);
    b_s     = (MW+2)'(pxf2) + (MW+2)'(pyf2);
    c_s     = (MW+2)'(pff2) + (MW+2)'(pgg2) - $signed((MW+2)'(rr2));
    nb_s    = -b_s;
    nc_s    = -c_s;
    ble_c   = b_s[MW+1] || (b_s == '0);
    cneg_c  = c_s[MW+1];
    czero_c = (c_s == '0);
    minus_c = ble_c && !cneg_c;
    plus_c  = !minus_c && (ble_c || cneg_c || czero_c);
  end

  always_ff @(posedge clk) begin
    if (rst) c3 <= '0;
    else if (en) c3 <= '{valid: c2.valid,
                         live: c2.live && (a_s != '0) && (minus_c || plus_c)};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmag3 <= cneg_c ? nc_s[MW-1:0] : c_s[MW-1:0];
      cneg3 <= cneg_c;
      side3 <= {minus_c, ble_c, (b_s[MW+1] ? nb_s[MW-1:0] : b_s[MW-1:0]),
                a_s[MW-1:0], geo2};
    end
  end

  // Stage 4: partial products of b*b and A*|C|
  rci_ctl_t c4;
  logic [MW-1:0]       a3, bm3;
  logic [2*H-1:0]      bll4, all4;
  logic [H+HW-1:0]     blh4, alh4, ahl4;
  logic [2*HW-1:0]     bhh4, ahh4;
  logic                cneg4;
  logic [SW-1:0]       side4;

  assign a3  = side3[GW +: MW];
  assign bm3 = side3[GW+MW +: MW];

  always_ff @(posedge clk) begin
    if (rst) c4 <= '0;
    else if (en) c4 <= c3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bll4  <= bm3[H-1:0] * bm3[H-1:0];
      blh4  <= bm3[H-1:0] * bm3[MW-1:H];
      bhh4  <= bm3[MW-1:H] * bm3[MW-1:H];
      all4  <= a3[H-1:0] * cmag3[H-1:0];
      alh4  <= a3[H-1:0] * cmag3[MW-1:H];
      ahl4  <= a3[MW-1:H] * cmag3[H-1:0];
      ahh4  <= a3[MW-1:H] * cmag3[MW-1:H];
      cneg4 <= cneg3;
      side4 <= side3;
    end
  end

  // Stage 5: join outer terms, sum cross terms
  rci_ctl_t c5;
  logic [2*MW-1:0] catb5, cata5;
  logic [MW:0]     midb5, mida5;
  logic            cneg5;
  logic [SW-1:0]   side5;

  always_ff @(posedge clk) begin
    if (rst) c5 <= '0;
    else if (en) c5 <= c4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      catb5 <= {bhh4, bll4};
      cata5 <= {ahh4, all4};
      midb5 <= {blh4, 1'b0};
      mida5 <= (MW+1)'(alh4) + (MW+1)'(ahl4);
      cneg5 <= cneg4;
      side5 <= side4;
    end
  end

  // Stage 6: full products
  rci_ctl_t c6;
  logic [2*MW-1:0] bsq6, ac6;
  logic            cneg6;
  logic [SW-1:0]   side6;

  always_ff @(posedge clk) begin
    if (rst) c6 <= '0;
    else if (en) c6 <= c5;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bsq6  <= catb5 + ((2*MW)'(midb5) << H);
      ac6   <= cata5 + ((2*MW)'(mida5) << H);
      cneg6 <= cneg5;
      side6 <= side5;
    end
  end

  // Stage 7: discriminant
  rci_ctl_t c7, csq_in;
  logic [2*MW:0] q7;
  logic [SW-1:0] side7;

  always_ff @(posedge clk) begin
    if (rst) c7 <= '0;
    else if (en) c7 <= c6;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q7    <= cneg6 ? (2*MW+1)'(bsq6) + (2*MW+1)'(ac6)
                     : (2*MW+1)'(bsq6) - (2*MW+1)'(ac6);
      side7 <= side6;
    end
  end

  assign csq_in = '{valid: c7.valid, live: c7.live && !q7[2*MW]};

  // Square root of the discriminant
  rci_ctl_t      csq;
  logic [MW-1:0] root_s;
  logic [SW-1:0] side_s;

  rci_sqrt_pipe #(.RB(MW), .SIDE_W(SW)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .ctl_in   (csq_in),
    .rad_in   (q7[2*MW-1:0]),
    .side_in  (side7),
    .ctl_out  (csq),
    .root_out (root_s),
    .side_out (side_s)
  );

  // Stage 8: root numerator
  rci_ctl_t      c8;
  logic [NW-1:0] n8, n_c;
  logic [MW-1:0] a8;
  logic [GW-1:0] geo8;
  logic [MW-1:0] bm_s;

  assign bm_s = side_s[GW+MW +: MW];

  always_comb begin
    if (side_s[GW+2*MW]) begin
      if (side_s[GW+2*MW+1]) n_c = NW'(bm_s) - NW'(root_s);
      else n_c = NW'(bm_s) + NW'(root_s);
    end else begin
      n_c = NW'(root_s) - NW'(bm_s);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) c8 <= '0;
    else if (en) c8 <= csq;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n8   <= n_c;
      a8   <= side_s[GW +: MW];
      geo8 <= side_s[GW-1:0];
    end
  end

  // Stage 9: |d| * n partial products
  rci_ctl_t        c9;
  logic [W+H-1:0]  xlo9, ylo9;
  logic [W+NH-1:0] xhi9, yhi9;
  logic [MW-1:0]   a9;
  logic [GW-1:0]   geo9;

  always_ff @(posedge clk) begin
    if (rst) c9 <= '0;
    else if (en) c9 <= c8;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xlo9 <= geo8[2*W +: W] * n8[H-1:0];
      xhi9 <= geo8[2*W +: W] * n8[NW-1:H];
      ylo9 <= geo8[3*W +: W] * n8[H-1:0];
      yhi9 <= geo8[3*W +: W] * n8[NW-1:H];
      a9   <= a8;
      geo9 <= geo8;
    end
  end

  // Stage 10: full products
  rci_ctl_t       c10;
  logic [MPW-1:0] mx10, my10;
  logic [MW-1:0]  a10;
  logic [GW-1:0]  geo10;

  always_ff @(posedge clk) begin
    if (rst) c10 <= '0;
    else if (en) c10 <= c9;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx10  <= MPW'(xlo9) + (MPW'(xhi9) << H);
      my10  <= MPW'(ylo9) + (MPW'(yhi9) << H);
      a10   <= a9;
      geo10 <= geo9;
    end
  end

  // Stage 11: rounding numerators and divisor
  rci_ctl_t        c11;
  logic [NNW-1:0]  nx11, ny11;
  logic [DENW-1:0] den11;
  logic [W:0]      sdx11, sdy11;

  always_ff @(posedge clk) begin
    if (rst) c11 <= '0;
    else if (en) c11 <= c10;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx11  <= NNW'({mx10, 1'b0}) + NNW'(a10);
      ny11  <= NNW'({my10, 1'b0}) + NNW'(a10);
      den11 <= {a10, 1'b0};
      sdx11 <= {geo10[4*W], geo10[0 +: W]};
      sdy11 <= {geo10[4*W+1], geo10[W +: W]};
    end
  end

  // Per-axis division
  rci_ctl_t      cdx, cdy;
  logic [QB-1:0] qx, qy;
  logic          ovx, ovy;
  logic [W:0]    sdx, sdy;

  rci_div_pipe #(.NUM_W(NNW), .DEN_W(DENW), .QB(QB), .SIDE_W(W+1)) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .ctl_in   (c11),
    .num_in   (nx11),
    .den_in   (den11),
    .side_in  (sdx11),
    .ctl_out  (cdx),
    .quo_out  (qx),
    .ovf_out  (ovx),
    .side_out (sdx)
  );

  rci_div_pipe #(.NUM_W(NNW), .DEN_W(DENW), .QB(QB), .SIDE_W(W+1)) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .ctl_in   (c11),
    .num_in   (ny11),
    .den_in   (den11),
    .side_in  (sdy11),
    .ctl_out  (cdy),
    .quo_out  (qy),
    .ovf_out  (ovy),
    .side_out (sdy)
  );

  // Add the signed step to the start and saturate
  function automatic logic [W-1:0] clamp_axis(input logic signed [W-1:0] s,
                                              input logic neg,
                                              input logic [QB-1:0] q,
                                              input logic ovf);
    logic signed [VW-1:0] qe;
    logic signed [VW-1:0] v;
    qe = $signed(VW'(q));
    v  = VW'(s) + (neg ? -qe : qe);
    if (ovf) v = neg ? MINV : MAXV;
    else if (v > MAXV) v = MAXV;
    else if (v < MINV) v = MINV;
    return v[W-1:0];
  endfunction

  // Stage 12: final result
  logic          v12;
  logic [OW-1:0] res12;
  logic          hit_c;

  assign hit_c = cdx.live && cdy.live;

  always_ff @(posedge clk) begin
    if (rst) v12 <= 1'b0;
    else if (en) v12 <= cdx.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res12 <= hit_c ? {1'b1, clamp_axis(sdy[W-1:0], sdy[W], qy, ovy),
                        clamp_axis(sdx[W-1:0], sdx[W], qx, ovx)}
                     : '0;
    end
  end

  // Output register with skid stage
  logic [OW-1:0] out_data, skid_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= v12;
      end
    end else if (v12 && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      out_data <= skid_valid ? skid_data : res12;
    end else if (!skid_valid) begin
      skid_data <= res12;
    end
  end

  assign m_tdata = ODW'(out_data[2*W-1:0]);
  assign m_tuser = out_data[2*W];

endmodule

`default_nettype wire

@@ hdl/rci_checker.sv @@
// ----------------------------------------------------------------------------
// rci_checker
// Port-level checks of the ray / circle intersection top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rci_checker #(
  parameter int COORD_WIDTH = 24
) (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
  input logic [0:0] m_tuser
);

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output word changed");

  // A miss carries zero coordinates
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("miss word with nonzero coordinates");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("output not empty after reset");

  // Input backpressure only while a result waits
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no pending output word");

endmodule

bind ray_circle_intersect_top rci_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rci_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
